[sv/tea_pkg.sv]
package tea_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MAX_ROUNDS  = 64;
  localparam int unsigned NUM_STAGES  = 2 * MAX_ROUNDS;
  localparam int unsigned ROUND_IDX_W = $clog2(MAX_ROUNDS);
  localparam int unsigned ROUND_CNT_W = $clog2(MAX_ROUNDS + 1);
  localparam int unsigned LOG2_W      = 3;
  localparam int unsigned MAX_LOG2    = $clog2(MAX_ROUNDS);

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_LOG2     = 3'd4;

  localparam logic [LOG2_W-1:0] ROUND_LOG2_RESET = 3'd5;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
  } tea_data_t;

  typedef struct packed {
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
  } tea_block_t;

  function automatic logic [LOG2_W-1:0] tea_log2_sat(input logic [LOG2_W-1:0] rl);
    logic [LOG2_W-1:0] r;
    r = (rl > LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : rl;
    return r;
  endfunction

  function automatic logic [ROUND_CNT_W-1:0] tea_round_count(input logic [LOG2_W-1:0] rl);
    logic [ROUND_CNT_W-1:0] r;
    r = ROUND_CNT_W'(1) << tea_log2_sat(rl);
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] tea_start_sum(input logic [LOG2_W-1:0] rl);
    logic [WORD_W-1:0] r;
    r = TEA_DELTA << tea_log2_sat(rl);
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] tea_mix(
    input logic [WORD_W-1:0] x,
    input logic [WORD_W-1:0] sum,
    input logic [WORD_W-1:0] ka,
    input logic [WORD_W-1:0] kb
  );
    logic [WORD_W-1:0] r;
    r = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
    return r;
  endfunction

endpackage

[sv/tea_if.sv]
interface tea_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] first_word;
  logic [31:0] second_word;

  modport source (output valid, output kind, output first_word, output second_word,
                  input ready);
  modport sink   (input valid, input kind, input first_word, input second_word,
                  output ready);
endinterface

interface tea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_first_word;
  logic [31:0] out_second_word;

  modport source (output valid, output out_first_word, output out_second_word,
                  input ready);
  modport sink   (input valid, input out_first_word, input out_second_word,
                  output ready);
endinterface

[sv/tea_stage.sv]
module tea_stage (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic [tea_pkg::ROUND_IDX_W-1:0]      round_i,
  input  logic                                 second_i,
  input  logic [tea_pkg::ROUND_CNT_W-1:0]      rounds_i,
  input  tea_pkg::tea_key_t                    key_i,
  input  logic                                 valid_i,
  input  tea_pkg::tea_data_t                   data_i,
  output logic                                 valid_o,
  output tea_pkg::tea_data_t                   data_o
);
  import tea_pkg::*;

  logic              active;
  logic              use_hi;
  logic [WORD_W-1:0] x;
  logic [WORD_W-1:0] upd;
  logic [WORD_W-1:0] ka;
  logic [WORD_W-1:0] kb;
  logic [WORD_W-1:0] m;
  logic [WORD_W-1:0] res;
  tea_data_t         data_d;
  tea_data_t         data_q;
  logic              valid_q;

  // encrypt: v0 half then v1 half; decrypt runs them the other way round
  always_comb begin
    active = {1'b0, round_i} < rounds_i;
    use_hi = second_i ^ data_i.kind;
    x      = use_hi ? data_i.v0 : data_i.v1;
    upd    = use_hi ? data_i.v1 : data_i.v0;
    ka     = use_hi ? key_i.k2 : key_i.k0;
    kb     = use_hi ? key_i.k3 : key_i.k1;
    m      = tea_mix(x, data_i.sum, ka, kb);
    res    = (data_i.kind == KIND_DECRYPT) ? (upd - m) : (upd + m);
    data_d = data_i;
    if (active) begin
      if (use_hi) begin
        data_d.v1 = res;
      end else begin
        data_d.v0 = res;
      end
      if (second_i) begin
        data_d.sum = (data_i.kind == KIND_DECRYPT) ? (data_i.sum - TEA_DELTA)
                                                   : (data_i.sum + TEA_DELTA);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[sv/tea_pipe.sv]
module tea_pipe (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  tea_pkg::tea_key_t               key_i,
  input  logic [tea_pkg::LOG2_W-1:0]      round_log2_i,
  input  logic                            valid_i,
  input  logic                            kind_i,
  input  logic [tea_pkg::WORD_W-1:0]      first_word_i,
  input  logic [tea_pkg::WORD_W-1:0]      second_word_i,
  output logic                            valid_o,
  output tea_pkg::tea_block_t             block_o
);
  import tea_pkg::*;

  logic                   valid_s [NUM_STAGES+1];
  tea_data_t              data_s  [NUM_STAGES+1];
  tea_data_t              entry_d;
  logic                   entry_valid_q;
  tea_data_t              entry_q;
  logic [ROUND_CNT_W-1:0] rounds;

  always_comb begin
    rounds        = tea_round_count(round_log2_i);
    entry_d.kind  = kind_i;
    entry_d.v0    = first_word_i;
    entry_d.v1    = second_word_i;
    entry_d.sum   = (kind_i == KIND_DECRYPT) ? tea_start_sum(round_log2_i) : TEA_DELTA;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (en_i) begin
      entry_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      entry_q <= entry_d;
    end
  end

  assign valid_s[0] = entry_valid_q;
  assign data_s[0]  = entry_q;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    tea_stage u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en_i),
      .round_i  (ROUND_IDX_W'(k >> 1)),
      .second_i (1'((k % 2))),
      .rounds_i (rounds),
      .key_i    (key_i),
      .valid_i  (valid_s[k]),
      .data_i   (data_s[k]),
      .valid_o  (valid_s[k+1]),
      .data_o   (data_s[k+1])
    );
  end

  assign valid_o    = valid_s[NUM_STAGES];
  assign block_o.v0 = data_s[NUM_STAGES].v0;
  assign block_o.v1 = data_s[NUM_STAGES].v1;

endmodule

[sv/tea_out_buf.sv]
module tea_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  tea_pkg::tea_block_t  block_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output tea_pkg::tea_block_t  block_o,
  input  logic                 ready_i
);
  import tea_pkg::*;

  logic       out_valid_q;
  logic       skid_valid_q;
  tea_block_t out_q;
  tea_block_t skid_q;
  logic       hold;

  assign ready_o = !skid_valid_q;
  assign hold    = out_valid_q && !ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!skid_valid_q) begin
      if (hold) begin
        skid_valid_q <= valid_i;
      end else begin
        out_valid_q <= valid_i;
      end
    end else if (ready_i) begin
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      if (hold) begin
        skid_q <= block_i;
      end else begin
        out_q <= block_i;
      end
    end else if (ready_i) begin
      out_q <= skid_q;
    end
  end

  assign valid_o = out_valid_q;
  assign block_o = out_q;

endmodule

[sv/tea_block_cipher.sv]
// TEA block cipher, 64-bit block, 128-bit key, fully unrolled.
// in_if carries one block (first_word, second_word) and kind (0 encrypt,
// 1 decrypt); out_if returns the transformed pair. A transaction completes on
// a rising edge with valid and ready both high.
// Config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0..3 key words,
// 4 round_log2); other indexes are ignored. Write only while the block is idle.
// Rounds = 2**round_log2, capped at 64; decrypt starts its sum at delta<<log2.
// Pipeline: one entry register, 128 half-round stages (two per round, the
// ones past the round count pass data through), then an output register.
// Every transaction passes through all of these registers, whatever the
// round count; throughput is one transaction per cycle unless stalled.
// Stall: a skid register behind the output holds one result, so in_if.ready
// only drops once both output slots are full; then the whole pipeline freezes.
// Reset clears all valid bits, keys to zero and round_log2 to 5 (32 rounds).
module tea_block_cipher (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tea_in_if.sink                            in_if,
  tea_out_if.source                         out_if,
  input  logic                              cfg_we_i,
  input  logic [tea_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tea_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tea_pkg::*;

  tea_key_t          key_q;
  logic [LOG2_W-1:0] round_log2_q;
  logic              pipe_en;
  logic              pipe_valid;
  tea_block_t        pipe_block;
  tea_block_t        out_block;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q        <= '0;
      round_log2_q <= ROUND_LOG2_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_WORD_ZERO:  key_q.k0     <= WORD_W'(cfg_data_i);
        REG_KEY_WORD_ONE:   key_q.k1     <= WORD_W'(cfg_data_i);
        REG_KEY_WORD_TWO:   key_q.k2     <= WORD_W'(cfg_data_i);
        REG_KEY_WORD_THREE: key_q.k3     <= WORD_W'(cfg_data_i);
        REG_ROUND_LOG2:     round_log2_q <= cfg_data_i[LOG2_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_if.ready = pipe_en;

  tea_pipe u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (pipe_en),
    .key_i         (key_q),
    .round_log2_i  (round_log2_q),
    .valid_i       (in_if.valid),
    .kind_i        (in_if.kind),
    .first_word_i  (in_if.first_word),
    .second_word_i (in_if.second_word),
    .valid_o       (pipe_valid),
    .block_o       (pipe_block)
  );

  tea_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pipe_valid),
    .block_i (pipe_block),
    .ready_o (pipe_en),
    .valid_o (out_if.valid),
    .block_o (out_block),
    .ready_i (out_if.ready)
  );

  assign out_if.out_first_word  = out_block.v0;
  assign out_if.out_second_word = out_block.v1;

  a_frozen_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |-> out_if.valid)
    else $error("pipeline frozen without a pending result");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready && pipe_valid && pipe_en) |=> !pipe_en)
    else $error("stalled result did not land in skid register");

  a_drain_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!pipe_en && out_if.ready) |=> pipe_en)
    else $error("skid register not released after output transaction");

endmodule
